FILE: rtl/core/efr_pkg.sv
package efr_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h2F;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'h0000;
    localparam logic [8:0]  FULL_LENGTH = 9'd256;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHK_HI  = 3'd6,
        PH_CHK_LO  = 3'd7
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_FRAME   = 1'b1
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } byte_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] command_code;
        logic [7:0] address_high;
        logic [7:0] address_low;
        logic [7:0] length_field;
        logic       check_ok;
    } result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/efr_if.sv
interface efr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] command_code;
    logic [7:0] address_high;
    logic [7:0] address_low;
    logic [7:0] length_field;
    logic       check_ok;

    modport source (
        output valid, input ready,
        output result_kind, output data_byte, output byte_index, output command_code,
        output address_high, output address_low, output length_field, output check_ok
    );
    modport sink (
        input valid, output ready,
        input result_kind, input data_byte, input byte_index, input command_code,
        input address_high, input address_low, input length_field, input check_ok
    );
endinterface

FILE: rtl/core/efr_in_stage.sv
module efr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    efr_in_if.sink             rx,
    input  logic               advance,
    output efr_pkg::byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       take;

    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (take)
        begin
            valid_next = 1'b1;
            byte_next  = rx.rx_byte;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

FILE: rtl/core/efr_parser.sv
module efr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  efr_pkg::byte_item_t item,
    input  logic                advance,
    output logic                produce,
    output efr_pkg::result_t    result
);

    efr_pkg::phase_t phase_reg;
    efr_pkg::phase_t phase_next;
    logic [7:0]      cmd_reg;
    logic [7:0]      cmd_next;
    logic [7:0]      addr_hi_reg;
    logic [7:0]      addr_hi_next;
    logic [7:0]      addr_lo_reg;
    logic [7:0]      addr_lo_next;
    logic [7:0]      len_reg;
    logic [7:0]      len_next;
    logic [15:0]     crc_reg;
    logic [15:0]     crc_next;
    logic [7:0]      chk_hi_reg;
    logic [7:0]      chk_hi_next;
    logic [8:0]      count_reg;
    logic [8:0]      count_next;
    logic [7:0]      b;
    logic [15:0]     crc_upd;
    logic [8:0]      count_inc;
    logic [8:0]      frame_len;

    assign b         = item.rx_byte;
    assign crc_upd   = efr_pkg::crc_step(crc_reg, b);
    assign count_inc = count_reg + 9'd1;
    assign frame_len = (len_reg == 8'd0) ? efr_pkg::FULL_LENGTH : {1'b0, len_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        addr_hi_next = addr_hi_reg;
        addr_lo_next = addr_lo_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        chk_hi_next  = chk_hi_reg;
        count_next   = count_reg;
        produce      = 1'b0;
        result       = '0;
        unique case (phase_reg)
            efr_pkg::PH_HUNT:
            begin
                if (b == efr_pkg::START_BYTE)
                begin
                    crc_next   = efr_pkg::crc_step(efr_pkg::CRC_INIT, b);
                    count_next = 9'd0;
                    phase_next = efr_pkg::PH_CMD;
                end
            end
            efr_pkg::PH_CMD:
            begin
                cmd_next   = b;
                crc_next   = crc_upd;
                phase_next = efr_pkg::PH_ADDR_HI;
            end
            efr_pkg::PH_ADDR_HI:
            begin
                addr_hi_next = b;
                crc_next     = crc_upd;
                phase_next   = efr_pkg::PH_ADDR_LO;
            end
            efr_pkg::PH_ADDR_LO:
            begin
                addr_lo_next = b;
                crc_next     = crc_upd;
                phase_next   = efr_pkg::PH_LEN;
            end
            efr_pkg::PH_LEN:
            begin
                len_next   = b;
                crc_next   = crc_upd;
                count_next = 9'd0;
                phase_next = efr_pkg::PH_PAYLOAD;
            end
            efr_pkg::PH_PAYLOAD:
            begin
                produce            = 1'b1;
                result.result_kind = efr_pkg::KIND_PAYLOAD;
                result.data_byte   = b;
                result.byte_index  = count_reg[7:0];
                crc_next           = crc_upd;
                count_next         = count_inc;
                if (count_inc >= frame_len)
                begin
                    phase_next = efr_pkg::PH_CHK_HI;
                end
            end
            efr_pkg::PH_CHK_HI:
            begin
                chk_hi_next = b;
                phase_next  = efr_pkg::PH_CHK_LO;
            end
            efr_pkg::PH_CHK_LO:
            begin
                produce             = 1'b1;
                result.result_kind  = efr_pkg::KIND_FRAME;
                result.command_code = cmd_reg;
                result.address_high = addr_hi_reg;
                result.address_low  = addr_lo_reg;
                result.length_field = len_reg;
                result.check_ok     = (crc_reg == {chk_hi_reg, b});
                phase_next          = efr_pkg::PH_HUNT;
                cmd_next            = 8'd0;
                addr_hi_next        = 8'd0;
                addr_lo_next        = 8'd0;
                len_next            = 8'd0;
                crc_next            = 16'd0;
                chk_hi_next         = 8'd0;
                count_next          = 9'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= efr_pkg::PH_HUNT;
            cmd_reg     <= 8'd0;
            addr_hi_reg <= 8'd0;
            addr_lo_reg <= 8'd0;
            len_reg     <= 8'd0;
            crc_reg     <= 16'd0;
            chk_hi_reg  <= 8'd0;
            count_reg   <= 9'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            addr_hi_reg <= addr_hi_next;
            addr_lo_reg <= addr_lo_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            chk_hi_reg  <= chk_hi_next;
            count_reg   <= count_next;
        end
    end

endmodule

FILE: rtl/core/efr_out_stage.sv
module efr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             produce,
    input  efr_pkg::result_t result,
    efr_out_if.source        results,
    output logic             room
);

    logic             valid_reg;
    logic             valid_next;
    efr_pkg::result_t data_reg;
    efr_pkg::result_t data_next;
    logic             load;

    assign room = !valid_reg || results.ready;
    assign load = advance && produce;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = result;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign results.valid        = valid_reg;
    assign results.result_kind  = data_reg.result_kind;
    assign results.data_byte    = data_reg.data_byte;
    assign results.byte_index   = data_reg.byte_index;
    assign results.command_code = data_reg.command_code;
    assign results.address_high = data_reg.address_high;
    assign results.address_low  = data_reg.address_low;
    assign results.length_field = data_reg.length_field;
    assign results.check_ok     = data_reg.check_ok;

endmodule

FILE: rtl/core/escaped_frame_receiver_crc16_unit.sv
// A byte is first registered in the input stage; its result, if any, in the output stage.
// One byte per cycle while the result register has room, set by the byte-wide CRC update.
// The input keeps flowing while a result waits, as long as the result register drains.
// Reset is asynchronous and active low; it empties both stages and returns to hunting.
module escaped_frame_receiver_crc16_unit (
    input  logic      clk,
    input  logic      rst_n,
    efr_in_if.sink    rx,
    efr_out_if.source results
);

    efr_pkg::byte_item_t item;
    efr_pkg::result_t    result;
    logic                produce;
    logic                room;
    logic                advance;

    assign advance = item.valid && room;

    efr_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .item    (item)
    );

    efr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .produce (produce),
        .result  (result)
    );

    efr_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .produce (produce),
        .result  (result),
        .results (results),
        .room    (room)
    );

endmodule

FILE: rtl/core/efr_checker.sv
module efr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       result_kind,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic [7:0] command_code,
    input logic [7:0] address_high,
    input logic [7:0] address_low,
    input logic [7:0] length_field,
    input logic       check_ok
);

    // A waiting result must keep its kind, data byte, index, command code and check flag until it is taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(data_byte)
            && $stable(byte_index) && $stable(command_code) && $stable(check_ok))
        else $error("result changed while stalled");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> command_code == 8'd0 && address_high == 8'd0
            && address_low == 8'd0 && length_field == 8'd0 && !check_ok)
        else $error("payload item carries frame fields");

    a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> data_byte == 8'd0 && byte_index == 8'd0)
        else $error("frame record carries payload fields");

    // With the sink ready the receiver never holds off the link.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output ready");

endmodule

bind escaped_frame_receiver_crc16_unit efr_checker u_efr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (rx.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .result_kind  (results.result_kind),
    .data_byte    (results.data_byte),
    .byte_index   (results.byte_index),
    .command_code (results.command_code),
    .address_high (results.address_high),
    .address_low  (results.address_low),
    .length_field (results.length_field),
    .check_ok     (results.check_ok)
);

FILE: tb/tb_escaped_frame_receiver_crc16_unit.sv
module tb_escaped_frame_receiver_crc16_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;

    efr_in_if  rx_ch ();
    efr_out_if res_ch ();

    escaped_frame_receiver_crc16_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .results (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0]        rx_bytes_q[$];
    efr_pkg::result_t  awaited_records_q[$];
    int                mismatch_count = 0;
    int                frame_bytes = 0;

    // Mirror of the receiver's parser state.
    efr_pkg::phase_t rx_phase = efr_pkg::PH_HUNT;
    logic [7:0]  held_cmd = '0;
    logic [7:0]  held_adr_hi = '0;
    logic [7:0]  held_adr_lo = '0;
    logic [7:0]  held_len = '0;
    logic [15:0] run_crc = '0;
    logic [15:0] rcv_crc = '0;
    logic [8:0]  pay_count = '0;

    int send_gap = 0;
    bit send_calm = 1'b0;
    int take_stall = 0;
    bit take_calm = 1'b0;

    function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ (16'(b) << 8);
        repeat (8) c = c[15] ? ((c << 1) ^ efr_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        efr_pkg::result_t rec;
        logic [8:0] body_len;
        rec = '0;
        body_len = (held_len == 8'd0) ? efr_pkg::FULL_LENGTH : {1'b0, held_len};
        case (rx_phase)
            efr_pkg::PH_HUNT:
            begin
                if (b == efr_pkg::START_BYTE)
                begin
                    run_crc = crc16_xmodem_byte(efr_pkg::CRC_INIT, b);
                    pay_count = '0;
                    rx_phase = efr_pkg::PH_CMD;
                end
            end
            efr_pkg::PH_CMD:
            begin
                held_cmd = b;
                run_crc = crc16_xmodem_byte(run_crc, b);
                rx_phase = efr_pkg::PH_ADDR_HI;
            end
            efr_pkg::PH_ADDR_HI:
            begin
                held_adr_hi = b;
                run_crc = crc16_xmodem_byte(run_crc, b);
                rx_phase = efr_pkg::PH_ADDR_LO;
            end
            efr_pkg::PH_ADDR_LO:
            begin
                held_adr_lo = b;
                run_crc = crc16_xmodem_byte(run_crc, b);
                rx_phase = efr_pkg::PH_LEN;
            end
            efr_pkg::PH_LEN:
            begin
                held_len = b;
                run_crc = crc16_xmodem_byte(run_crc, b);
                pay_count = '0;
                rx_phase = efr_pkg::PH_PAYLOAD;
            end
            efr_pkg::PH_PAYLOAD:
            begin
                rec.result_kind = efr_pkg::KIND_PAYLOAD;
                rec.data_byte = b;
                rec.byte_index = pay_count[7:0];
                awaited_records_q.push_back(rec);
                run_crc = crc16_xmodem_byte(run_crc, b);
                pay_count = pay_count + 9'd1;
                if (pay_count >= body_len)
                begin
                    rx_phase = efr_pkg::PH_CHK_HI;
                end
            end
            efr_pkg::PH_CHK_HI:
            begin
                rcv_crc = {b, 8'h00};
                rx_phase = efr_pkg::PH_CHK_LO;
            end
            default:
            begin
                rcv_crc[7:0] = b;
                rec.result_kind = efr_pkg::KIND_FRAME;
                rec.command_code = held_cmd;
                rec.address_high = held_adr_hi;
                rec.address_low = held_adr_lo;
                rec.length_field = held_len;
                rec.check_ok = (run_crc == rcv_crc);
                awaited_records_q.push_back(rec);
                rx_phase = efr_pkg::PH_HUNT;
                held_cmd = '0;
                held_adr_hi = '0;
                held_adr_lo = '0;
                held_len = '0;
                run_crc = '0;
                rcv_crc = '0;
                pay_count = '0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
        end
    endtask

    // A positive keep count below the full frame size cuts the frame short.
    task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] adr_hi,
                               input logic [7:0] adr_lo, input logic [7:0] len,
                               input logic [7:0] body[$], input bit bad_check,
                               input int keep);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        frame = {efr_pkg::START_BYTE, cmd, adr_hi, adr_lo, len};
        foreach (body[i])
        begin
            frame.push_back(body[i]);
        end
        crc = efr_pkg::CRC_INIT;
        foreach (frame[i])
        begin
            crc = crc16_xmodem_byte(crc, frame[i]);
        end
        if (bad_check)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        if (keep > 0)
        begin
            while (frame.size() > keep)
            begin
                void'(frame.pop_back());
            end
        end
        foreach (frame[i])
        begin
            rx_bytes_q.push_back(frame[i]);
        end
        frame_bytes += frame.size();
    endtask

    always @(posedge clk)
    begin
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        nxt_valid = rx_ch.valid;
        nxt_byte = rx_ch.rx_byte;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                parse_rx_byte(rx_ch.rx_byte);
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                begin
                    send_calm = !send_calm;
                end
                send_gap = send_calm ? 0 : $urandom_range(0, 12);
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (rx_bytes_q.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_byte = rx_bytes_q.pop_front();
                end
            end
        end
        rx_ch.valid <= nxt_valid;
        rx_ch.rx_byte <= nxt_byte;
    end

    always @(posedge clk)
    begin
        logic             nxt_ready;
        efr_pkg::result_t want;
        nxt_ready = res_ch.ready;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_records_q.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want = awaited_records_q.pop_front();
                    compare_field("result_kind", 8'(res_ch.result_kind),
                                  8'(want.result_kind));
                    compare_field("data_byte", res_ch.data_byte, want.data_byte);
                    compare_field("byte_index", res_ch.byte_index, want.byte_index);
                    compare_field("command_code", res_ch.command_code, want.command_code);
                    compare_field("address_high", res_ch.address_high, want.address_high);
                    compare_field("address_low", res_ch.address_low, want.address_low);
                    compare_field("length_field", res_ch.length_field, want.length_field);
                    compare_field("check_ok", 8'(res_ch.check_ok), 8'(want.check_ok));
                end
                nxt_ready = 1'b0;
                if ($urandom_range(0, 39) == 0)
                begin
                    take_calm = !take_calm;
                end
                take_stall = take_calm ? 0 : $urandom_range(0, 12);
            end
            if (!nxt_ready)
            begin
                if (take_stall > 0)
                begin
                    take_stall--;
                end
                else
                begin
                    nxt_ready = 1'b1;
                end
            end
        end
        res_ch.ready <= nxt_ready;
    end

    initial
    begin
        logic [7:0] body[$];
        logic [7:0] len;
        logic [7:0] b;
        int         sel;
        int         body_len;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        rst_n = 1'b0;

        // Bytes seen while hunting are dropped.
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'hFF);
        rx_bytes_q.push_back(8'h2E);
        rx_bytes_q.push_back(8'hD0);
        body = {8'h00};
        queue_frame(8'hFF, 8'h00, 8'hFF, 8'h01, body, 1'b0, 0);
        // A start byte inside the payload is plain data.
        body = {efr_pkg::START_BYTE, 8'hFF};
        queue_frame(8'h00, 8'hFF, 8'h00, 8'h02, body, 1'b1, 0);

        // Longest frames: a zero length means the full payload.
        body.delete();
        repeat (256) body.push_back(8'($urandom_range(0, 255)));
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'h00, body, 1'b0, 0);
        body.delete();
        repeat (255) body.push_back(8'($urandom_range(0, 255)));
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'hFF, body, 1'b1, 0);

        while (frame_bytes < 1600)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == efr_pkg::START_BYTE && $urandom_range(0, 7) != 0)
                    begin
                        b = 8'h2E;
                    end
                    rx_bytes_q.push_back(b);
                end
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                begin
                    len = 8'h00;
                end
                else if (sel < 6)
                begin
                    len = 8'($urandom_range(200, 255));
                end
                else
                begin
                    len = 8'($urandom_range(1, 16));
                end
                body_len = (len == 8'h00) ? 256 : len;
                body.delete();
                repeat (body_len) body.push_back(8'($urandom_range(0, 255)));
                sel = $urandom_range(0, 99);
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), len, body,
                            $urandom_range(0, 3) == 0,
                            (sel < 10) ? $urandom_range(1, body_len + 6) : 0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_bytes_q.size() != 0 || rx_ch.valid)
        begin
            @(posedge clk);
        end
        while (awaited_records_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("escaped_frame_receiver_crc16_unit: match");
        end
        else
        begin
            $display("escaped_frame_receiver_crc16_unit: mismatch");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("escaped_frame_receiver_crc16_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/efr_pkg.sv
rtl/core/efr_if.sv
rtl/core/efr_in_stage.sv
rtl/core/efr_parser.sv
rtl/core/efr_out_stage.sv
rtl/core/escaped_frame_receiver_crc16_unit.sv
rtl/core/efr_checker.sv
tb/tb_escaped_frame_receiver_crc16_unit.sv
